// ===== rtl/core/gha_pkg.sv =====
// Shared types and constants for the generational handle allocator.
// Depends on nothing; generational_handle_allocator refers to it by scoped names.
`timescale 1ns / 1ps

package gha_pkg;

    // Default sizes
    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_GEN_BITS = 16;

    // Fixed field widths
    localparam int ID_W   = 12;
    localparam int GEN_W  = 16;
    localparam int LIVE_W = 11;

    // Id reserved as "no handle"
    localparam logic [ID_W-1:0] INVALID_ID = '1;

    // Operation codes
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DEAD = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Request word
    typedef struct packed {
        logic [1:0]       opcode;
        logic [ID_W-1:0]  handle_id;
        logic [GEN_W-1:0] handle_generation;
    } t_req;

    // Result word
    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   new_id;
        logic [GEN_W-1:0]  new_generation;
        logic [LIVE_W-1:0] live_count;
    } t_rsp;

endpackage

// ===== rtl/core/generational_handle_allocator.sv =====
// Generational handle allocator: create, destroy and check of id+generation handles.
// Steps: a create from a fresh id, a create with no free id and an unused opcode
// answer from idle; destroy/check take a lookup; a create from the free stack does a
// stack read, then a generation read. One word at a time: busy is high while a word
// is in the pop, generation or lookup states, and a new word is taken only in idle.
// Synchronous active-low reset empties the free stack and clears all counters; the
// result strobe cannot be stalled. Depends on gha_pkg and gha_ram.
`timescale 1ns / 1ps

module generational_handle_allocator #(
    parameter int CAPACITY = gha_pkg::DEF_CAPACITY,
    parameter int GEN_BITS = gha_pkg::DEF_GEN_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  gha_pkg::t_req i_req,
    output logic          o_done,
    output gha_pkg::t_rsp o_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = gha_pkg::ID_W + 1;
    localparam logic [31:0] GEN_MASK =
        (GEN_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << GEN_BITS) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_GEN,
        S_LOOK
    } t_state;

    t_state r_state, n_state;

    logic [1:0]               r_op;
    logic [gha_pkg::ID_W-1:0]  r_id;
    logic [gha_pkg::GEN_W-1:0] r_gen;
    logic [IW-1:0]            r_pop_id;
    logic [CW-1:0]            r_depth, n_depth;
    logic [CW-1:0]            r_fresh, n_fresh;
    logic [CW-1:0]            r_live, n_live;
    logic                     r_done, n_done;
    gha_pkg::t_rsp            r_rsp, n_rsp;

    // Memory ports
    logic                gt_wr_en, gt_rd_en;
    logic [IW-1:0]       gt_wr_addr, gt_rd_addr;
    logic [GEN_BITS-1:0] gt_wr_data, gt_rd_data;
    logic                st_wr_en, st_rd_en;
    logic [IW-1:0]       st_wr_addr, st_rd_addr;
    logic [IW-1:0]       st_wr_data, st_rd_data;

    logic                accept;
    logic                alive;
    logic [GEN_BITS-1:0] gen_inc;

    gha_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (GEN_BITS)
    ) u_gen_table (
        .i_clk     (i_clk),
        .i_wr_en   (gt_wr_en),
        .i_wr_addr (gt_wr_addr),
        .i_wr_data (gt_wr_data),
        .i_rd_en   (gt_rd_en),
        .i_rd_addr (gt_rd_addr),
        .o_rd_data (gt_rd_data)
    );

    gha_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (IW)
    ) u_free_stack (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Liveness of the latched handle against the looked-up generation
    assign alive = (r_gen != '0) && (r_id != gha_pkg::INVALID_ID)
                && ({1'b0, r_id} < XW'(r_fresh)) && ({1'b0, r_id} < XW'(CAPACITY))
                && (32'(gt_rd_data) == (32'(r_gen) & GEN_MASK));

    // Next generation, skipping zero on wrap
    always_comb begin
        gen_inc = gt_rd_data + 1'b1;
        if (gen_inc == '0) begin
            gen_inc = GEN_BITS'(1);
        end
    end

    // Sequence memory accesses and compute the next state and result
    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_fresh    = r_fresh;
        n_live     = r_live;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        gt_wr_en   = 1'b0;
        gt_wr_addr = IW'(r_id);
        gt_wr_data = gen_inc;
        gt_rd_en   = 1'b0;
        gt_rd_addr = IW'(i_req.handle_id);
        st_wr_en   = 1'b0;
        st_wr_addr = IW'(r_depth);
        st_wr_data = IW'(r_id);
        st_rd_en   = 1'b0;
        st_rd_addr = IW'(r_depth - 1'b1);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.opcode)
                        gha_pkg::OP_CREATE: begin
                            if (r_depth != '0) begin
                                // pop a recycled id, its generation follows
                                st_rd_en = 1'b1;
                                n_depth  = r_depth - 1'b1;
                                n_state  = S_POP;
                            end else if (r_fresh < CW'(CAPACITY)) begin
                                // hand out a fresh id at generation one
                                gt_wr_en   = 1'b1;
                                gt_wr_addr = IW'(r_fresh);
                                gt_wr_data = GEN_BITS'(1);
                                n_fresh    = r_fresh + 1'b1;
                                n_live     = r_live + 1'b1;
                                n_done     = 1'b1;
                                n_rsp.status         = gha_pkg::ST_OK;
                                n_rsp.new_id         = gha_pkg::ID_W'(r_fresh);
                                n_rsp.new_generation = gha_pkg::GEN_W'(1);
                                n_rsp.live_count     = gha_pkg::LIVE_W'(n_live);
                            end else begin
                                n_done = 1'b1;
                                n_rsp.status         = gha_pkg::ST_FULL;
                                n_rsp.new_id         = '0;
                                n_rsp.new_generation = '0;
                                n_rsp.live_count     = gha_pkg::LIVE_W'(r_live);
                            end
                        end
                        gha_pkg::OP_DESTROY, gha_pkg::OP_CHECK: begin
                            gt_rd_en = 1'b1;
                            n_state  = S_LOOK;
                        end
                        default: begin
                            n_done = 1'b1;
                            n_rsp.status         = gha_pkg::ST_DEAD;
                            n_rsp.new_id         = '0;
                            n_rsp.new_generation = '0;
                            n_rsp.live_count     = gha_pkg::LIVE_W'(r_live);
                        end
                    endcase
                end
            end
            S_POP: begin
                // look up the generation of the popped id
                gt_rd_en   = 1'b1;
                gt_rd_addr = st_rd_data;
                n_state    = S_GEN;
            end
            S_GEN: begin
                n_live  = r_live + 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
                n_rsp.status         = gha_pkg::ST_OK;
                n_rsp.new_id         = gha_pkg::ID_W'(r_pop_id);
                n_rsp.new_generation = gha_pkg::GEN_W'(gt_rd_data);
                n_rsp.live_count     = gha_pkg::LIVE_W'(n_live);
            end
            S_LOOK: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                n_rsp.status         = alive ? gha_pkg::ST_OK : gha_pkg::ST_DEAD;
                n_rsp.new_id         = '0;
                n_rsp.new_generation = '0;
                if (alive && (r_op == gha_pkg::OP_DESTROY)) begin
                    // bump generation, recycle id, drop live count
                    gt_wr_en = 1'b1;
                    if (r_depth < CW'(CAPACITY)) begin
                        st_wr_en = 1'b1;
                        n_depth  = r_depth + 1'b1;
                    end
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end
                n_rsp.live_count = gha_pkg::LIVE_W'(n_live);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, counters and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_fresh <= '0;
            r_live  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_fresh <= n_fresh;
            r_live  <= n_live;
            r_done  <= n_done;
        end
        r_rsp <= n_rsp;
        if (accept) begin
            r_op  <= i_req.opcode;
            r_id  <= i_req.handle_id;
            r_gen <= i_req.handle_generation;
        end
        if (r_state == S_POP) begin
            r_pop_id <= st_rd_data;
        end
    end

`ifndef SYNTHESIS
    // Every id handed out is either live or waiting on the free stack,
    // except while a popped id is still on its way to the result
    a_id_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_POP) && (r_state != S_GEN)
        |-> (32'(r_depth) + 32'(r_live)) == 32'(r_fresh))
        else $error("free stack depth plus live count differs from fresh count");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= CW'(CAPACITY))
        else $error("fresh id counter beyond capacity");

    a_pop_then_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_state == S_GEN) && !o_done)
        else $error("stack pop not followed by generation lookup");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status == gha_pkg::ST_OK) || (o_rsp.status == gha_pkg::ST_DEAD)
                || (o_rsp.status == gha_pkg::ST_FULL))
        else $error("result carries an unknown status code");
`endif

endmodule

// ===== rtl/core/gha_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered. No package dependency.
`timescale 1ns / 1ps

module gha_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
